[hdl/base32_stream_encoder_assert.svh]
// Assertion macros shared by the base32 stream encoder modules.
// No dependencies; each using module supplies its own clock and reset names.
`ifndef BASE32_STREAM_ENCODER_ASSERT_SVH
`define BASE32_STREAM_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B32E_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B32E_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/b32e_pkg.sv]
// Shared types, constants and the symbol lookup for the base32 stream encoder.
// No dependencies.
package b32e_pkg;

  localparam int unsigned GROUP_W = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ACC_W   = 12;
  localparam int unsigned HELD_W  = 4;
  localparam int unsigned COUNT_W = 16;

  localparam logic [HELD_W-1:0] GROUP_BITS = 4'd5;
  localparam logic [HELD_W-1:0] BYTE_BITS  = 4'd8;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd512;

  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_2     = 8'h32;
  localparam logic [7:0] NUM_LETTERS = 8'd26;

  // One 5-bit group handed from the front end to the back end.
  typedef struct packed {
    logic               msg_end;
    logic [GROUP_W-1:0] idx;
  } grp_t;

  // One result as it waits in the output queue.
  typedef struct packed {
    logic [7:0]         symbol;
    logic               final_res;
    logic [COUNT_W-1:0] emitted;
  } res_t;

  // A-Z for 0-25, 2-7 for 26-31.
  function automatic logic [7:0] b32_char(input logic [GROUP_W-1:0] idx);
    logic [7:0] wide;
    wide = {3'b000, idx};
    if (wide < NUM_LETTERS) begin
      return ASCII_A + wide;
    end else begin
      return ASCII_2 + (wide - NUM_LETTERS);
    end
  endfunction

endpackage

[hdl/b32e_queue.sv]
// Small register-based FIFO used between the encoder stages and at the output.
// No dependencies.
module b32e_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[hdl/b32e_front.sv]
// Front end: takes bytes, keeps the bit accumulator and splits it into 5-bit groups.
// Depends on b32e_pkg and base32_stream_encoder_assert.svh.
`include "base32_stream_encoder_assert.svh"

module b32e_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [b32e_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          last_byte,
  output logic                          full,
  output logic                          grp_push,
  output b32e_pkg::grp_t                grp,
  input  logic                          grp_full
);

  logic [b32e_pkg::ACC_W-1:0]  acc;
  logic [b32e_pkg::HELD_W-1:0] held;
  logic                        last_q;
  logic                        busy;

  logic                        has_full;
  logic [b32e_pkg::HELD_W-1:0] held_after;
  logic [b32e_pkg::HELD_W-1:0] held_base;
  logic [b32e_pkg::GROUP_W-1:0] idx_full;
  logic [b32e_pkg::GROUP_W-1:0] idx_pad;
  logic                        grp_valid;
  logic                        more_groups;
  logic                        byte_done;
  logic                        in_fire;

  always_comb begin
    has_full   = (held >= b32e_pkg::GROUP_BITS);
    idx_full   = b32e_pkg::GROUP_W'(acc >> (held - b32e_pkg::GROUP_BITS));
    idx_pad    = b32e_pkg::GROUP_W'(acc << (b32e_pkg::GROUP_BITS - held));
    held_after = has_full ? (held - b32e_pkg::GROUP_BITS) : '0;
    grp_valid  = busy && (has_full || (last_q && (held != '0)));

    grp.idx     = has_full ? idx_full : idx_pad;
    grp.msg_end = last_q && (held_after == '0);
    grp_push    = grp_valid && !grp_full;

    // Another group still pending from this byte after the current one.
    more_groups = (held_after >= b32e_pkg::GROUP_BITS) ||
                  (last_q && (held_after != '0));
    byte_done   = !busy || (grp_push && !more_groups);
    full        = !byte_done;
    in_fire     = push && byte_done;
    held_base   = busy ? held_after : held;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc <= {acc[b32e_pkg::ACC_W-b32e_pkg::BYTE_W-1:0], data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= '0;
      last_q <= 1'b0;
      busy   <= 1'b0;
    end else if (in_fire) begin
      held   <= held_base + b32e_pkg::BYTE_BITS;
      last_q <= last_byte;
      busy   <= 1'b1;
    end else if (grp_push) begin
      held <= held_after;
      if (!more_groups) begin
        busy <= 1'b0;
      end
    end
  end

  // A new byte may enter a busy front end only as its final group leaves.
  `B32E_ASSERT_NOW(a_accept_on_final, clk, rst, in_fire && busy, grp_push && !more_groups,
    "byte accepted while groups of the previous byte remain")

endmodule

[hdl/b32e_back.sv]
// Back end: counts symbols, applies the output limit and forms result items.
// Depends on b32e_pkg and base32_stream_encoder_assert.svh.
`include "base32_stream_encoder_assert.svh"

module b32e_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [b32e_pkg::COUNT_W-1:0]  out_limit,
  input  logic                          grp_empty,
  input  b32e_pkg::grp_t                grp,
  output logic                          grp_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output b32e_pkg::res_t                res
);

  logic [b32e_pkg::COUNT_W-1:0] symbol_count;
  logic                         cut_off;
  logic                         drop;
  logic [b32e_pkg::COUNT_W-1:0] cnt_inc;
  logic                         reach;

  always_comb begin
    drop     = cut_off || (out_limit == '0);
    cnt_inc  = symbol_count + b32e_pkg::COUNT_W'(1);
    reach    = (cnt_inc >= out_limit);
    grp_pop  = !grp_empty && (drop || !res_full);
    res_push = grp_pop && !drop;

    res.symbol    = b32e_pkg::b32_char(grp.idx);
    res.final_res = grp.msg_end || reach;
    res.emitted   = cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      cut_off      <= 1'b0;
    end else if (grp_pop) begin
      if (grp.msg_end) begin
        symbol_count <= '0;
        cut_off      <= 1'b0;
      end else if (!drop) begin
        symbol_count <= cnt_inc;
        if (reach) begin
          cut_off <= 1'b1;
        end
      end
    end
  end

  `B32E_ASSERT_NEXT(a_msg_clear, clk, rst, grp_pop && grp.msg_end,
    (symbol_count == '0) && !cut_off, "message state not cleared at message end")
  `B32E_ASSERT_NOW(a_cut_has_count, clk, rst, cut_off, symbol_count != '0,
    "cut off without any symbol emitted")

endmodule

[hdl/base32_stream_encoder.sv]
// Top level of the base32 stream encoder: limit register, front end, group
// queue, back end and output queue. Depends on b32e_pkg, b32e_queue,
// b32e_front, b32e_back and base32_stream_encoder_assert.svh.
//
// Streaming base32 encoder (A-Z then 2-7, no '=' padding). Bytes enter through
// a queue-style port (push/full) with last_byte marking the end of a message;
// symbols leave through a queue-style port (empty/pop), each carrying its
// ASCII code, a final_res flag and the running count of symbols emitted for
// the message. Each byte yields one or two symbols, plus a zero-padded symbol
// on the last byte when bits are left over. Output for a message stops at
// out_limit symbols; the symbol that reaches the limit is flagged final and
// the rest of that message is swallowed. Write out_limit only while the block
// is idle; a value of zero suppresses all output. Timing: the front end turns
// a byte into groups at one group per cycle while the group queue has room; a
// byte yields one to three groups (two for most bytes). The back end and the
// output channel move one symbol per cycle while the output queue has room,
// so with pop held high the sustained rate is set by the symbol stream. A
// byte's first symbol passes the accumulator, group queue and output queue.
`include "base32_stream_encoder_assert.svh"

module base32_stream_encoder #(
  parameter int unsigned GRP_DEPTH = 4,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // byte input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // symbol output
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  symbol,
  output logic        final_res,
  output logic [15:0] emitted
);

  logic [b32e_pkg::COUNT_W-1:0] out_limit;

  logic           grp_push;
  logic           grp_full;
  logic           grp_empty;
  logic           grp_pop;
  b32e_pkg::grp_t grp_in;
  b32e_pkg::grp_t grp_out;
  logic [$bits(b32e_pkg::grp_t)-1:0] grp_dout;

  logic           res_push;
  logic           res_full;
  b32e_pkg::res_t res_in;
  b32e_pkg::res_t res_out;
  logic [$bits(b32e_pkg::res_t)-1:0] res_dout;

  // Symbol limit; users must write it only while the block is idle (unchecked).
  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= b32e_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      out_limit <= cfg_wr_data;
    end
  end

  // Split bytes into 5-bit groups, one group per cycle while the group queue has room.
  b32e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .full      (full),
    .grp_push  (grp_push),
    .grp       (grp_in),
    .grp_full  (grp_full)
  );

  // Decouple group generation from limit handling and output stalls.
  b32e_queue #(
    .WIDTH ($bits(b32e_pkg::grp_t)),
    .DEPTH (GRP_DEPTH)
  ) u_grp_q (
    .clk   (clk),
    .rst   (rst),
    .push  (grp_push),
    .din   (grp_in),
    .full  (grp_full),
    .pop   (grp_pop),
    .dout  (grp_dout),
    .empty (grp_empty)
  );

  assign grp_out = b32e_pkg::grp_t'(grp_dout);

  // Count symbols, apply the limit, map groups to ASCII.
  b32e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .out_limit (out_limit),
    .grp_empty (grp_empty),
    .grp       (grp_out),
    .grp_pop   (grp_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Output queue: the head entry drives the result ports.
  b32e_queue #(
    .WIDTH ($bits(b32e_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign res_out   = b32e_pkg::res_t'(res_dout);
  assign symbol    = res_out.symbol;
  assign final_res = res_out.final_res;
  assign emitted   = res_out.emitted;

  // A waiting result always counts at least itself.
  `B32E_ASSERT_NOW(a_emitted_nonzero, clk, rst, !empty, emitted != 16'd0,
    "result waiting with a zero symbol count")

endmodule

[verif/base32_stream_encoder_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for base32_stream_encoder: byte transfers, limit writes, symbol checks.
// Depends on b32e_pkg (res_t) and the encoder RTL; holds its own symbol predictor.

class b32_symbol_predictor;
  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
  bit [15:0] limit;
  bit [11:0] accum;
  int held;
  bit [15:0] count;
  bit cut;
  b32e_pkg::res_t pending_symbols[$];
  int mismatches;

  function new();
    limit = 16'd512;
    clear_message();
    mismatches = 0;
  endfunction

  function void set_limit(bit [15:0] value);
    limit = value;
  endfunction

  function void clear_message();
    accum = '0;
    held = 0;
    count = '0;
    cut = 1'b0;
  endfunction

  function void queue_symbol(bit [4:0] idx, bit natural_end);
    b32e_pkg::res_t r;
    count = count + 16'd1;
    r.symbol = alphabet[idx];
    r.final_res = natural_end || (count >= limit);
    r.emitted = count;
    if (count >= limit) cut = 1'b1;
    pending_symbols = {pending_symbols, r};
  endfunction

  // Note one accepted byte and queue every symbol it must produce.
  function void take_byte(bit [7:0] data, bit last);
    bit [4:0] idx;
    if (limit == 16'd0) cut = 1'b1;
    if (!cut) begin
      accum = {accum[3:0], data};
      held = (held & 7) + 8;
      if (held > 12) held = 12;
      while (!cut && held >= 5) begin
        idx = 5'(accum >> (held - 5));
        held = held - 5;
        queue_symbol(idx, last && held == 0);
      end
      if (last && !cut && held > 0) begin
        idx = 5'(accum << (5 - held));
        held = 0;
        queue_symbol(idx, 1'b1);
      end
    end
    if (last) clear_message();
  endfunction

  // Compare one transferred symbol with the oldest one predicted.
  function void check_symbol(logic [7:0] sym, logic fin, logic [15:0] cnt);
    b32e_pkg::res_t want;
    if (pending_symbols.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected symbol %h final %b emitted %0d", $realtime, sym, fin, cnt);
    end else begin
      want = pending_symbols[0];
      pending_symbols.delete(0);
      if (want.symbol !== sym || want.final_res !== fin || want.emitted !== cnt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: symbol mismatch: expected %h/%b/%0d, got %h/%b/%0d", $realtime,
                   want.symbol, want.final_res, want.emitted, sym, fin, cnt);
      end
    end
  endfunction
endclass

module base32_stream_encoder_test;

  // Every input starts at a known value; reset is held from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        push = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  symbol;
  logic        final_res;
  logic [15:0] emitted;

  localparam int DIRECTED_BYTES = 21;
  localparam int RANDOM_BYTES   = 88;
  // Cycles to let a byte finish in the block even when it yields no symbol.
  localparam int SETTLE_CYCLES  = 20;

  b32_symbol_predictor sym_pred;
  int bytes_sent = 0;
  bit burst = 1'b0;

  base32_stream_encoder uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .empty      (empty),
    .pop        (pop),
    .symbol     (symbol),
    .final_res  (final_res),
    .emitted    (emitted)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // Check each symbol transfer. Values read at the edge are the pre-edge ones,
  // i.e. exactly what the block sampled.
  always @(posedge clk) begin
    if (!rst && pop && !empty) sym_pred.check_symbol(symbol, final_res, emitted);
  end

  // Receiver: alternate stretches of steady pop, random short stalls and
  // occasional long stalls so back-pressure lands on every phase.
  initial begin
    int mode;
    int span;
    wait (!rst);
    forever begin
      mode = $urandom_range(0, 9);
      span = (mode >= 8) ? $urandom_range(5, 40) : $urandom_range(1, 30);
      repeat (span) begin
        if (mode < 4) pop <= 1'b1;
        else if (mode < 8) pop <= ($urandom_range(0, 3) != 0);
        else pop <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Offer one byte and hold it until the transfer; push stays high afterwards
  // so back-to-back bytes need no extra edge.
  task automatic send_byte(input logic [7:0] data, input logic last);
    push <= 1'b1;
    data_byte <= data;
    last_byte <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    sym_pred.take_byte(data, last);
    bytes_sent++;
  endtask

  // Insert a sender gap: mostly none, some short, a few long. Skip in bursts.
  task automatic pace();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = 0;
    if (burst || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every predicted symbol has been transferred,
  // then let any byte that yields nothing drain out of the block.
  task automatic drain();
    push <= 1'b0;
    while (sym_pred.pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the symbol limit; call only after drain().
  task automatic write_limit(input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sym_pred.set_limit(value);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
      pace();
    end
  endtask

  // Pick a limit: some that let messages finish, some that cut them
  // short, one and the register's maximum among them.
  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 16'd1;
      1:       return 16'($urandom_range(2, 12));
      2:       return 16'd512;
      3:       return 16'hFFFF;
      4:       return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(5, 30));
    endcase
  endfunction

  initial begin
    int len;
    sym_pred = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-byte messages at both byte extremes: one full group plus a pad.
    send_byte(8'h00, 1'b1);
    pace();
    send_byte(8'hFF, 1'b1);
    pace();

    // Forty bits: the last group is complete, so no pad symbol follows.
    send_byte(8'hF8, 1'b0);
    send_byte(8'h3E, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'hE0, 1'b1);
    pace();

    // Three bytes leave four bits over for the pad symbol.
    send_byte(8'h55, 1'b0);
    pace();
    send_byte(8'hAA, 1'b0);
    send_byte(8'h80, 1'b1);

    // Cut off after three symbols; the rest of the message is swallowed.
    drain();
    write_limit(16'd3);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);

    // Limit of one: first symbol is final.
    drain();
    write_limit(16'd1);
    send_byte(8'h7F, 1'b1);

    // Limit of zero: the whole message yields nothing.
    drain();
    write_limit(16'd0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);

    // Lower the limit mid-message below the count already emitted: the next
    // symbol still goes out, marked final, and nothing after it.
    drain();
    write_limit(16'hFFFF);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    drain();
    write_limit(16'd2);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hEF, 1'b1);
    drain();
    write_limit(16'd512);

    // Random whole messages; change the limit now and then, and sometimes
    // pause the sender until the output has caught up.
    while (bytes_sent < DIRECTED_BYTES + RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_limit(pick_limit());
      end else if ($urandom_range(0, 9) == 0) begin
        drain();
      end
      burst = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      send_message(len);
      burst = 1'b0;
    end

    drain();
    if (sym_pred.mismatches == 0 && sym_pred.pending_symbols.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
